// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // Word queue depth between front and core (one full block).
    localparam int WQ_DEPTH = 16;

    // One queue entry: a big-endian message word, flagged on the last word
    // of the final (padded) block of a message.
    typedef struct packed {
        logic        final_blk;
        logic [31:0] word;
    } wq_entry_t;

    // Initial hash value, H0 in the top word.
    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] h_init_word(input logic [2:0] idx);
        logic [31:0] w;
        w = H_INIT[255 - 32 * int'(idx) -: 32];
        return w;
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// File: design/sha256_wq.sv
// ----------------------------------------------------------------------------
// sha256_wq
// Word queue between the byte front end and the compression core.
// ----------------------------------------------------------------------------
module sha256_wq #(
    parameter int DEPTH = sha256_pkg::WQ_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sha256_pkg::wq_entry_t din,
    output logic                  full,
    input  logic                  pop,
    output sha256_pkg::wq_entry_t dout,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha256_pkg::wq_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("word queue count out of range");

endmodule

// File: design/sha256_front.sv
// ----------------------------------------------------------------------------
// sha256_front
// Takes data/finish beats, packs bytes into words, inserts padding and the
// bit length, and pushes words into the word queue.
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [7:0]            data_byte,
    output logic                  q_push,
    output sha256_pkg::wq_entry_t q_din,
    input  logic                  q_full
);

    localparam logic F_DATA = 1'b0;
    localparam logic F_PAD  = 1'b1;

    logic        state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [23:0] pack_reg, pack_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        len_ok_reg, len_ok_next;
    logic        acc, wr_en, tag, len_phase;
    logic [7:0]  wr_byte;

    assign full      = (state_reg == F_PAD) || q_full;
    assign acc       = push && !full;
    assign len_phase = len_ok_reg && (pos_reg >= 6'd56);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        tag     = 1'b0;
        unique case (state_reg)
            F_DATA:
            begin
                wr_en   = acc;
                wr_byte = kind ? 8'h80 : data_byte;
            end
            F_PAD:
            begin
                wr_en   = !q_full;
                wr_byte = len_phase ? bitlen_reg[63:56] : 8'h00;
                tag     = len_ok_reg && (pos_reg == 6'd63);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign q_push          = wr_en && (pos_reg[1:0] == 2'b11);
    assign q_din.final_blk = tag;
    assign q_din.word      = {pack_reg, wr_byte};

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        pack_next   = pack_reg;
        bitlen_next = bitlen_reg;
        len_ok_next = len_ok_reg;
        if (wr_en)
        begin
            pos_next  = pos_reg + 1'b1;
            pack_next = {pack_reg[15:0], wr_byte};
        end
        unique case (state_reg)
            F_DATA:
            begin
                if (acc && !kind)
                begin
                    bitlen_next = bitlen_reg + 64'd8;
                end
                else if (acc && kind)
                begin
                    state_next  = F_PAD;
                    // length fits in this block, or 0x80 closes it exactly
                    len_ok_next = (pos_reg < 6'd56) || (pos_reg == 6'd63);
                end
            end
            F_PAD:
            begin
                if (wr_en)
                begin
                    if (len_phase)
                    begin
                        bitlen_next = {bitlen_reg[55:0], 8'h00};
                    end
                    if (tag)
                    begin
                        state_next  = F_DATA;
                        len_ok_next = 1'b0;
                    end
                    else if (pos_reg == 6'd63)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = F_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_DATA;
            pos_reg    <= '0;
            bitlen_reg <= '0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            bitlen_reg <= bitlen_next;
            len_ok_reg <= len_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("word pushed into full queue");

    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && tag) |=> (state_reg == F_DATA) && (bitlen_reg == '0)
                            && (pos_reg == '0))
        else $error("front not back at message start after final word");

endmodule

// File: design/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Compression engine: one round per cycle while queue words are on hand,
// rolling 16-word schedule, eight-word digest buffer drained at result port.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::wq_entry_t q_dout,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_ROUND = 2'd1;
    localparam logic [1:0] B_DONE  = 2'd2;

    logic [1:0]  state_reg;
    logic [5:0]  rnd_reg;
    logic        final_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] win_reg  [16];
    logic [31:0] dig_reg  [8];
    logic [2:0]  idx_reg;
    logic        dig_valid_reg;

    logic        step, load_work, do_load_dig, out_pop;
    logic [31:0] w, w_calc, t1, t2;

    assign q_pop  = (state_reg == B_ROUND) && (rnd_reg[5:4] == 2'b00) && !q_empty;
    assign step   = (state_reg == B_ROUND) && ((rnd_reg[5:4] != 2'b00) || !q_empty);
    assign load_work   = (state_reg == B_IDLE) && !q_empty;
    assign do_load_dig = (state_reg == B_DONE) && final_reg && !dig_valid_reg;
    assign out_pop     = pop && dig_valid_reg;

    assign w_calc = sha256_pkg::small_s1(win_reg[14]) + win_reg[9]
                  + sha256_pkg::small_s0(win_reg[1]) + win_reg[0];
    assign w      = (rnd_reg[5:4] == 2'b00) ? q_dout.word : w_calc;

    assign t1 = work_reg[7] + sha256_pkg::big_s1(work_reg[4])
              + sha256_pkg::ch_f(work_reg[4], work_reg[5], work_reg[6])
              + sha256_pkg::round_k(rnd_reg) + w;
    assign t2 = sha256_pkg::big_s0(work_reg[0])
              + sha256_pkg::maj_f(work_reg[0], work_reg[1], work_reg[2]);

    assign empty       = !dig_valid_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rnd_reg       <= '0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
            dig_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256_pkg::h_init_word(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (load_work)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= B_ROUND;
                    end
                end
                B_ROUND:
                begin
                    if (q_pop)
                    begin
                        final_reg <= q_dout.final_blk;
                    end
                    if (step)
                    begin
                        rnd_reg <= rnd_reg + 1'b1;
                        if (rnd_reg == 6'd63)
                        begin
                            state_reg <= B_DONE;
                        end
                    end
                end
                B_DONE:
                begin
                    if (!final_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_reg[i] <= hash_reg[i] + work_reg[i];
                        end
                        state_reg <= B_IDLE;
                    end
                    else if (do_load_dig)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_reg[i] <= sha256_pkg::h_init_word(3'(i));
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            if (do_load_dig)
            begin
                dig_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_pop)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 3'd7)
                begin
                    dig_valid_reg <= 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end

        if (step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w;
        end

        if (do_load_dig)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dig_reg[i] <= hash_reg[i] + work_reg[i];
            end
        end
        else if (out_pop)
        begin
            for (int i = 0; i < 7; i++)
            begin
                dig_reg[i] <= dig_reg[i + 1];
            end
        end
    end

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_empty && (state_reg == B_ROUND) && (rnd_reg < 6'd16)))
        else $error("word popped outside the load rounds");

    a_dig_load: assert property (@(posedge clk) disable iff (!rst_n)
        do_load_dig |=> (!empty && (word_index == 3'd0) && (state_reg == B_IDLE)))
        else $error("digest load did not present word 0");

endmodule

// File: design/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 digest of a byte stream; eight digest words out per finish beat.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while the 16-word queue has room; a
//   block passes through the core as a load step, 64 rounds and a hash add.
//   A finish beat holds off the input while its padding goes out, one byte
//   per cycle while the queue has room.
// Digest: the core compresses words as they arrive; digest word 0 shows
//   once the final block's rounds are done and its digest is loaded.
// Reset: asynchronous, active low; hash words return to the initial values,
//   queue and digest buffer are empty. No clearing pass.
// ----------------------------------------------------------------------------
module sha256_message_hasher #(
    parameter int WQ_DEPTH = sha256_pkg::WQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input side: byte or finish beats
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    // result side: digest word beats
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // Word path from front end to core. The front end keeps packing and
    // padding on its own; the core drains words during rounds 0..15 of
    // each block, so the queue lets the next block build up while the
    // current one compresses.
    sha256_pkg::wq_entry_t q_din;
    sha256_pkg::wq_entry_t q_dout;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;

    // Front end: accepts beats, tracks byte position and bit length,
    // inserts 0x80, zero fill and the big-endian length.
    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .data_byte (data_byte),
        .q_push    (q_push),
        .q_din     (q_din),
        .q_full    (q_full)
    );

    sha256_wq #(
        .DEPTH (WQ_DEPTH)
    ) u_wq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // Core: compression rounds and the digest buffer. A final block waits
    // in its add step until the previous digest has fully drained.
    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_dout      (q_dout),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - SHA-256 message hasher
// Feeds byte and finish beats through the push/full queue port and drains
// digest words through empty/pop. A scoreboard class keeps its own SHA-256
// state (pending block, bit count, chaining words) and checks each popped
// word against the oldest predicted digest word.
// ----------------------------------------------------------------------------
package hasher_tb_pkg;

    // Input beat kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int DIGEST_WORDS = 8;
    localparam int BLOCK_BYTES  = 64;
    localparam int LENGTH_SLOT  = 56;   // first byte of the bit-length field

    localparam logic [31:0] IV_WORDS [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    class digest_scoreboard;

        typedef struct {
            logic [31:0] word;
            logic [2:0]  index;
            logic        last;
        } digest_beat_t;

        logic [7:0]   block_bytes [BLOCK_BYTES];
        int           fill;
        logic [63:0]  message_bits;
        logic [31:0]  chain [DIGEST_WORDS];
        digest_beat_t digest_q [$];

        int errors;
        int words_checked;
        int messages;
        int blocks;

        function new();
            errors        = 0;
            words_checked = 0;
            messages      = 0;
            blocks        = 0;
            start_message();
        endfunction

        function void start_message();
            fill         = 0;
            message_bits = '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain[i] = IV_WORDS[i];
        endfunction

        function logic [31:0] rotr(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            for (int r = 0; r < 16; r++)
                w[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
            for (int r = 16; r < 64; r++) begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = s1 + w[r-7] + s0 + w[r-16];
            end
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int r = 0; r < 64; r++) begin
                s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
                s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
            blocks++;
        endfunction

        // Called for every accepted input beat.
        function void note_beat(input logic kind, input logic [7:0] data);
            int pos;
            digest_beat_t d;
            if (kind == KIND_DATA) begin
                block_bytes[fill] = data;
                fill++;
                message_bits += 64'd8;
                if (fill == BLOCK_BYTES) begin
                    compress_block();
                    fill = 0;
                end
                return;
            end
            // finish: 0x80 marker, zero fill, 64-bit big-endian bit count
            block_bytes[fill] = 8'h80;
            pos = fill + 1;
            if (pos > LENGTH_SLOT) begin
                while (pos < BLOCK_BYTES) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LENGTH_SLOT) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[LENGTH_SLOT + i] = message_bits[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                d.word  = chain[i];
                d.index = 3'(i);
                d.last  = (i == DIGEST_WORDS - 1);
                digest_q.push_back(d);
            end
            messages++;
            start_message();
        endfunction

        task report(input string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        // Called for every popped digest word.
        task check_word(input logic [31:0] word, input logic [2:0] index,
                        input logic last);
            digest_beat_t d;
            if (digest_q.size() == 0) begin
                report($sformatf("digest word %h idx %0d popped with none pending",
                                 word, index));
                return;
            end
            d = digest_q.pop_front();
            words_checked++;
            if (word !== d.word)
                report($sformatf("digest_word idx %0d: got %h want %h", d.index, word, d.word));
            if (index !== d.index)
                report($sformatf("word_index: got %0d want %0d", index, d.index));
            if (last !== d.last)
                report($sformatf("last_word idx %0d: got %b want %b", d.index, last, d.last));
        endtask

        function int pending();
            return digest_q.size();
        endfunction

    endclass

endpackage

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 7;
    // Wide margin over the worst finish-to-digest-word-0 delay.
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 400000;
    // Drain hold-off long enough for digests to back up the core and the
    // word queue, so the input has to stall.
    localparam int HOLD_CYCLES   = 1500;
    localparam int PHASE_ITEMS   = 12;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic        kind      = hasher_tb_pkg::KIND_DATA;
    logic [7:0]  data_byte = 8'h00;
    logic        empty;
    logic        pop       = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    hasher_tb_pkg::digest_scoreboard sb;

    // Idle rates in percent, set per phase by the stimulus thread.
    int  send_idle    = 0;
    int  recv_idle    = 0;
    bit  hold_request = 1'b0;
    int  cycles       = 0;
    int  beats_sent   = 0;
    bit  full_seen    = 1'b0;

    sha256_message_hasher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always #2 clk = ~clk;

    // Cycle count for the watchdog; also notes backpressure on the input.
    always @(posedge clk) begin
        cycles++;
        if (push && full)
            full_seen = 1'b1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drain side. A beat moves at an edge where pop was high and empty low;
    // both are sampled before the DUT's updates at that edge land.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_word(digest_word, word_index, last_word);
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // One input beat: optional idle cycles, then hold push until accepted.
    // push stays high between back-to-back beats, so it never gets two
    // updates in one step.
    task automatic send_beat(input logic k, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.note_beat(k, b);
        beats_sent++;
    endtask

    // Bias toward the all-zero and all-one bytes now and then.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    // Short messages; the phase budget trims the last one.
    function automatic int pick_length();
        return int'($urandom_range(0, 9));
    endfunction

    // Finish beat carries a random byte; the DUT must ignore it.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(hasher_tb_pkg::KIND_DATA, pick_byte());
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'($urandom));
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct);
        int n;
        int len;
        send_idle = sender_pct;
        recv_idle = receiver_pct;
        n = 0;
        while (n < PHASE_ITEMS) begin
            len = pick_length();
            if (len + 1 > PHASE_ITEMS - n)
                len = PHASE_ITEMS - n - 1;
            send_message(len);
            n += len + 1;
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message (finish with a stray byte), "abc",
        // extreme byte values, a finish right after a finish, one byte.
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'hff);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h61);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h62);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h63);
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'h00);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h00);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'hff);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h80);
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'h55);
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'haa);
        send_beat(hasher_tb_pkg::KIND_DATA, 8'h7f);
        send_beat(hasher_tb_pkg::KIND_FINISH, 8'h01);

        // Backpressure: drain held off while the sender keeps offering.
        // One digest sits in the output buffer, the next final block waits
        // in the core, and the third message fills the word queue. The
        // 56-byte message needs an extra padding block.
        hold_request = 1'b1;
        send_message(1);
        send_message(56);
        send_message(1);

        // Random traffic under the three idle mixes.
        run_phase(20, 71);
        run_phase(71, 20);
        run_phase(0, 0);
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        // Catch any stray word that trails the last digest.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d beats in, %0d messages hashed, %0d blocks, %0d digest words checked",
                 beats_sent, sb.messages, sb.blocks, sb.words_checked);
        $display("run: input backpressure %s, %0d mismatches",
                 full_seen ? "exercised" : "not exercised", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
